@@ hdl/ddsf_pkg.sv @@
`timescale 1ns / 1ps

package ddsf_pkg;

  // stream payload widths
  localparam int unsigned ValW        = 32;
  localparam int unsigned InDataW     = 6 * ValW;
  localparam int unsigned TorqueW     = 14;
  localparam int unsigned OutDataW    = 32;
  localparam int unsigned GainW       = 16;

  // apb
  localparam int unsigned AddrW       = 5;
  localparam int unsigned DataW       = 32;

  // arithmetic widths
  localparam int unsigned MeasW       = ValW + 1;     // forward and forward rate
  localparam int unsigned ErrW        = ValW + 2;
  localparam int unsigned ProdW       = ErrW + GainW;
  localparam int unsigned SumW        = ProdW + 2;
  localparam int unsigned FracShift   = 16;
  localparam int unsigned CmdW        = SumW - FracShift;

  // 0.12 and 0.04 truncated to q16.16
  localparam int          FwdTol      = 7864;
  localparam int          FwdStep     = 2621;
  // +-10 and +-20 in q8.8
  localparam int          SpinLim     = 2560;
  localparam int          WheelLim    = 5120;

  localparam logic signed [ValW-1:0] UpperLimitRst = 32'sd65536;

  typedef enum logic [2:0] {
    REG_GAIN_POS       = 3'd0,
    REG_GAIN_VEL       = 3'd1,
    REG_GAIN_SPIN      = 3'd2,
    REG_GAIN_SPIN_RATE = 3'd3,
    REG_LOWER_LIMIT    = 3'd4,
    REG_UPPER_LIMIT    = 3'd5,
    REG_CONTROL_ENABLE = 3'd6,
    REG_DRIVE_ENABLE   = 3'd7
  } reg_idx_e;

endpackage

@@ hdl/diff_drive_state_feedback_unit.sv @@
`timescale 1ns / 1ps

// Differential-drive state feedback controller. Each stream transaction carries
// the two wheel positions and velocities with body tilt and tilt rate (Q16.16)
// and produces one transaction with left and right wheel torque commands (Q6.8,
// clamped to +-20). The block takes one transaction per clock cycle unless the
// output stalls; each result passes the input register, which loads at acceptance,
// then the reference update and error stage, the gain multiply stage, and the sum,
// clamp and mix stage into the output register. The reference update for one item
// completes within the error stage, which is what allows consecutive items with no
// gap. Each stage holds its item only while the one after it is full, so the input
// side keeps accepting until four transactions, the output register's included,
// wait on a stalled output. The user is to write gains, limits and enables over the
// APB port while no transactions are in flight; the block does not enforce this.
// With either enable cleared both torques read zero but the reference still tracks.

module diff_drive_state_feedback_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // apb configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ddsf_pkg::AddrW-1:0]    paddr,
  input  logic [ddsf_pkg::DataW-1:0]    pwdata,
  output logic [ddsf_pkg::DataW-1:0]    prdata,
  output logic                          pready,
  // sensor samples
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // left_pos, right_pos, left_vel, right_vel, tilt, tilt_rate
  input  logic [ddsf_pkg::InDataW-1:0]  s_axis_tdata_i,
  // capture_ref
  input  logic                          s_axis_tuser_i,
  // torque commands
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // left_torque, right_torque, zero padding
  output logic [ddsf_pkg::OutDataW-1:0] m_axis_tdata_o
);
  import ddsf_pkg::*;

  localparam logic signed [ErrW-1:0] TolPos   = ErrW'(FwdTol);
  localparam logic signed [ErrW-1:0] TolNeg   = -ErrW'(FwdTol);
  localparam logic signed [MeasW-1:0] StepVal = MeasW'(FwdStep);
  localparam logic signed [CmdW-1:0] SpinPos  = CmdW'(SpinLim);
  localparam logic signed [CmdW-1:0] SpinNeg  = -CmdW'(SpinLim);
  localparam logic signed [CmdW:0]   WheelPos = (CmdW+1)'(WheelLim);
  localparam logic signed [CmdW:0]   WheelNeg = -(CmdW+1)'(WheelLim);

  function automatic logic signed [ValW-1:0] sat32(input logic signed [MeasW-1:0] v);
    logic signed [ValW-1:0] r;
    if (v[MeasW-1] != v[MeasW-2]) begin
      r = v[MeasW-1] ? {1'b1, {(ValW-1){1'b0}}} : {1'b0, {(ValW-1){1'b1}}};
    end else begin
      r = v[ValW-1:0];
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- config
  logic signed [GainW-1:0] gain_pos_q, gain_vel_q, gain_spin_q, gain_spin_rate_q;
  logic signed [ValW-1:0]  lower_limit_q, upper_limit_q;
  logic                    control_enable_q, drive_enable_q;
  logic                    cfg_wr;
  reg_idx_e                cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_e'(paddr[AddrW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_pos_q       <= '0;
      gain_vel_q       <= '0;
      gain_spin_q      <= '0;
      gain_spin_rate_q <= '0;
      lower_limit_q    <= '0;
      upper_limit_q    <= UpperLimitRst;
      control_enable_q <= 1'b0;
      drive_enable_q   <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_GAIN_POS:       gain_pos_q       <= pwdata[GainW-1:0];
        REG_GAIN_VEL:       gain_vel_q       <= pwdata[GainW-1:0];
        REG_GAIN_SPIN:      gain_spin_q      <= pwdata[GainW-1:0];
        REG_GAIN_SPIN_RATE: gain_spin_rate_q <= pwdata[GainW-1:0];
        REG_LOWER_LIMIT:    lower_limit_q    <= pwdata[ValW-1:0];
        REG_UPPER_LIMIT:    upper_limit_q    <= pwdata[ValW-1:0];
        REG_CONTROL_ENABLE: control_enable_q <= pwdata[0];
        REG_DRIVE_ENABLE:   drive_enable_q   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_GAIN_POS:       prdata = DataW'(gain_pos_q);
      REG_GAIN_VEL:       prdata = DataW'(gain_vel_q);
      REG_GAIN_SPIN:      prdata = DataW'(gain_spin_q);
      REG_GAIN_SPIN_RATE: prdata = DataW'(gain_spin_rate_q);
      REG_LOWER_LIMIT:    prdata = DataW'(lower_limit_q);
      REG_UPPER_LIMIT:    prdata = DataW'(upper_limit_q);
      REG_CONTROL_ENABLE: prdata = DataW'(control_enable_q);
      REG_DRIVE_ENABLE:   prdata = DataW'(drive_enable_q);
      default:            prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- flow control
  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4 = !v4_q || m_axis_tready_i;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign s_axis_tready_o = rdy1;
  assign m_axis_tvalid_o = v4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_axis_tvalid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // ---------------------------------------------------------------- stage 1: input register
  logic [InDataW-1:0] in_data_q;
  logic               in_cap_q;

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      in_data_q <= s_axis_tdata_i;
      in_cap_q  <= s_axis_tuser_i;
    end
  end

  // ---------------------------------------------------------------- stage 2: reference and errors
  logic signed [ValW-1:0]  lp, rp, lv, rv, ti, tr;
  logic signed [MeasW-1:0] pos_sum, vel_sum, pos_dif, vel_dif;
  logic signed [MeasW-1:0] fwd, fwd_r;
  logic signed [ValW-1:0]  spn, spn_r;
  logic                    capture;
  logic signed [ValW-1:0]  ref_f_cap, ref_fr_cap, ref_s_cap, ref_sr_cap;
  logic signed [ErrW-1:0]  fwd_gap;
  logic                    in_tol;
  logic                    mov_d;
  logic signed [MeasW-1:0] stepped;
  logic signed [ValW-1:0]  ref_f_d;
  logic signed [ErrW-1:0]  e0_d, e1_d, e2_d, e3_d;

  logic signed [ValW-1:0]  ref_f_q, ref_fr_q, ref_s_q, ref_sr_q;
  logic                    mov_q, ref_valid_q;
  logic signed [ErrW-1:0]  e0_q, e1_q, e2_q, e3_q;
  logic                    en2_q;
  logic                    upd;

  assign lp = in_data_q[0*ValW +: ValW];
  assign rp = in_data_q[1*ValW +: ValW];
  assign lv = in_data_q[2*ValW +: ValW];
  assign rv = in_data_q[3*ValW +: ValW];
  assign ti = in_data_q[4*ValW +: ValW];
  assign tr = in_data_q[5*ValW +: ValW];

  assign pos_sum = MeasW'(lp) + MeasW'(rp);
  assign vel_sum = MeasW'(lv) + MeasW'(rv);
  assign pos_dif = MeasW'(rp) - MeasW'(lp);
  assign vel_dif = MeasW'(rv) - MeasW'(lv);

  // half sums fit in 32 bits, so adding tilt needs only one more
  assign fwd   = MeasW'(ValW'(pos_sum >>> 1)) + MeasW'(ti);
  assign fwd_r = MeasW'(ValW'(vel_sum >>> 1)) + MeasW'(tr);
  assign spn   = ValW'(pos_dif >>> 1);
  assign spn_r = ValW'(vel_dif >>> 1);

  assign capture    = !ref_valid_q || in_cap_q;
  assign ref_f_cap  = capture ? sat32(fwd)   : ref_f_q;
  assign ref_fr_cap = capture ? sat32(fwd_r) : ref_fr_q;
  assign ref_s_cap  = capture ? spn          : ref_s_q;
  assign ref_sr_cap = capture ? spn_r        : ref_sr_q;

  assign fwd_gap = ErrW'(ref_f_cap) - ErrW'(fwd);
  assign in_tol  = (fwd_gap > TolNeg) && (fwd_gap < TolPos);

  // lower limit test wins when both limits are crossed
  always_comb begin
    mov_d = mov_q;
    if (in_tol) begin
      if (fwd > MeasW'(upper_limit_q)) mov_d = 1'b0;
      if (fwd < MeasW'(lower_limit_q)) mov_d = 1'b1;
    end
  end

  assign stepped = mov_d ? MeasW'(ref_f_cap) + StepVal : MeasW'(ref_f_cap) - StepVal;
  assign ref_f_d = in_tol ? sat32(stepped) : ref_f_cap;

  assign e0_d = ErrW'(fwd)   - ErrW'(ref_f_d);
  assign e1_d = ErrW'(fwd_r) - ErrW'(ref_fr_cap);
  assign e2_d = ErrW'(spn)   - ErrW'(ref_s_cap);
  assign e3_d = ErrW'(spn_r) - ErrW'(ref_sr_cap);

  assign upd = rdy2 && v1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_f_q     <= '0;
      ref_fr_q    <= '0;
      ref_s_q     <= '0;
      ref_sr_q    <= '0;
      mov_q       <= 1'b1;
      ref_valid_q <= 1'b0;
    end else if (upd) begin
      ref_f_q     <= ref_f_d;
      ref_fr_q    <= ref_fr_cap;
      ref_s_q     <= ref_s_cap;
      ref_sr_q    <= ref_sr_cap;
      mov_q       <= mov_d;
      ref_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      e0_q  <= e0_d;
      e1_q  <= e1_d;
      e2_q  <= e2_d;
      e3_q  <= e3_d;
      en2_q <= control_enable_q && drive_enable_q;
    end
  end

  // ---------------------------------------------------------------- stage 3: gain products
  logic signed [ProdW-1:0] p0_q, p1_q, p2_q, p3_q;
  logic                    en3_q;

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      p0_q  <= ProdW'(gain_pos_q)       * ProdW'(e0_q);
      p1_q  <= ProdW'(gain_vel_q)       * ProdW'(e1_q);
      p2_q  <= ProdW'(gain_spin_q)      * ProdW'(e2_q);
      p3_q  <= ProdW'(gain_spin_rate_q) * ProdW'(e3_q);
      en3_q <= en2_q;
    end
  end

  // ---------------------------------------------------------------- stage 4: sum, clamp, mix
  logic signed [SumW-1:0]  sum_x, sum_s;
  logic signed [CmdW-1:0]  ux, us, us_c;
  logic signed [CmdW:0]    mix_l, mix_r;
  logic signed [TorqueW-1:0] left_d, right_d;
  logic [OutDataW-1:0]     out_data_q;

  assign sum_x = SumW'(p1_q) - SumW'(p0_q);
  assign sum_s = -(SumW'(p2_q) + SumW'(p3_q));
  assign ux    = CmdW'(sum_x >>> FracShift);
  assign us    = CmdW'(sum_s >>> FracShift);

  assign us_c  = (us > SpinPos) ? SpinPos : ((us < SpinNeg) ? SpinNeg : us);
  assign mix_l = (CmdW+1)'(ux) + (CmdW+1)'(us_c);
  assign mix_r = (CmdW+1)'(ux) - (CmdW+1)'(us_c);

  always_comb begin
    if (!en3_q) begin
      left_d  = '0;
      right_d = '0;
    end else begin
      left_d  = (mix_l > WheelPos) ? TorqueW'(WheelPos) :
                (mix_l < WheelNeg) ? TorqueW'(WheelNeg) : TorqueW'(mix_l);
      right_d = (mix_r > WheelPos) ? TorqueW'(WheelPos) :
                (mix_r < WheelNeg) ? TorqueW'(WheelNeg) : TorqueW'(mix_r);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy4) begin
      out_data_q <= {{(OutDataW - 2*TorqueW){1'b0}}, right_d, left_d};
    end
  end

  assign m_axis_tdata_o = out_data_q;

endmodule

@@ hdl/ddsf_checker.sv @@
`timescale 1ns / 1ps

module ddsf_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tready_i,
  input logic                          m_axis_tvalid_i,
  input logic                          m_axis_tready_i,
  input logic [ddsf_pkg::OutDataW-1:0] m_axis_tdata_i
);
  import ddsf_pkg::*;

  logic signed [TorqueW-1:0] left_t, right_t;

  assign left_t  = m_axis_tdata_i[TorqueW-1:0];
  assign right_t = m_axis_tdata_i[2*TorqueW-1:TorqueW];

  // input side only stalls when the output register is full and blocked
  a_no_needless_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_i |-> m_axis_tvalid_i && !m_axis_tready_i)
    else $error("input stalled while output side free");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i |-> m_axis_tdata_i[OutDataW-1:2*TorqueW] == '0)
    else $error("padding bits of result nonzero");

  a_torque_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i |-> (left_t <= TorqueW'(WheelLim)) && (left_t >= -TorqueW'(WheelLim)) &&
                        (right_t <= TorqueW'(WheelLim)) && (right_t >= -TorqueW'(WheelLim)))
    else $error("torque command outside wheel limit");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && !m_axis_tready_i |=> m_axis_tvalid_i && $stable(m_axis_tdata_i))
    else $error("stalled result changed");

endmodule

bind diff_drive_state_feedback_unit ddsf_checker u_ddsf_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_i (s_axis_tready_o),
  .m_axis_tvalid_i (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_i  (m_axis_tdata_o)
);

@@ bench/torque_checker.sv @@
`timescale 1ns / 1ps

module torque_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // apb writes, to follow the register settings
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ddsf_pkg::AddrW-1:0]    paddr,
  input  logic [ddsf_pkg::DataW-1:0]    pwdata,
  input  logic                          pready,
  // sample stream
  input  logic                          s_axis_tvalid_i,
  input  logic                          s_axis_tready_i,
  // left_pos, right_pos, left_vel, right_vel, tilt, tilt_rate
  input  logic [ddsf_pkg::InDataW-1:0]  s_axis_tdata_i,
  // capture_ref
  input  logic                          s_axis_tuser_i,
  // torque stream
  input  logic                          m_axis_tvalid_i,
  input  logic                          m_axis_tready_i,
  // left_torque, right_torque, zero padding
  input  logic [ddsf_pkg::OutDataW-1:0] m_axis_tdata_i,
  output int unsigned                   mismatch_cnt_o,
  output int unsigned                   pending_cnt_o
);
  import ddsf_pkg::*;

  localparam longint Q16Max = 64'sh0000_0000_7FFF_FFFF;
  localparam longint Q16Min = -64'sh0000_0000_8000_0000;
  localparam int unsigned PrintCap = 100;

  typedef struct {
    logic signed [TorqueW-1:0] left;
    logic signed [TorqueW-1:0] right;
  } torque_pair_t;

  torque_pair_t torque_q[$];
  torque_pair_t want;
  logic signed [TorqueW-1:0] got_left, got_right;

  longint k_pos, k_vel, k_spin, k_spin_rate;
  longint lim_lo, lim_hi;
  bit     ctrl_en, drive_en;

  longint ref_fwd, ref_fwd_rate, ref_spin, ref_spin_rate;
  bit     heading_up, ref_held;

  function automatic longint clamp_to(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint sat_q16(longint v);
    return clamp_to(v, Q16Min, Q16Max);
  endfunction

  // advances the reference state by one sample and returns the wheel commands
  function automatic torque_pair_t predict_torques(logic [InDataW-1:0] d, logic cap);
    longint lp, rp, lv, rv, ti, tr;
    longint fwd, fwd_r, spn, spn_r, gap, ux, us, ul, ur;
    torque_pair_t res;
    lp = longint'($signed(d[0*ValW +: ValW]));
    rp = longint'($signed(d[1*ValW +: ValW]));
    lv = longint'($signed(d[2*ValW +: ValW]));
    rv = longint'($signed(d[3*ValW +: ValW]));
    ti = longint'($signed(d[4*ValW +: ValW]));
    tr = longint'($signed(d[5*ValW +: ValW]));

    fwd   = ((lp + rp) >>> 1) + ti;
    fwd_r = ((lv + rv) >>> 1) + tr;
    spn   = (rp - lp) >>> 1;
    spn_r = (rv - lv) >>> 1;

    if (!ref_held || cap) begin
      ref_fwd       = sat_q16(fwd);
      ref_fwd_rate  = sat_q16(fwd_r);
      ref_spin      = sat_q16(spn);
      ref_spin_rate = sat_q16(spn_r);
      ref_held      = 1'b1;
    end

    gap = ref_fwd - fwd;
    if (gap > -FwdTol && gap < FwdTol) begin
      // upper test first, so crossed limits leave the reference heading up
      if (fwd > lim_hi) heading_up = 1'b0;
      if (fwd < lim_lo) heading_up = 1'b1;
      ref_fwd = sat_q16(heading_up ? ref_fwd + FwdStep : ref_fwd - FwdStep);
    end

    ul = 0;
    ur = 0;
    if (ctrl_en && drive_en) begin
      ux = (-(k_pos * (fwd - ref_fwd)) + k_vel * (fwd_r - ref_fwd_rate)) >>> FracShift;
      us = (-(k_spin * (spn - ref_spin) + k_spin_rate * (spn_r - ref_spin_rate)))
           >>> FracShift;
      us = clamp_to(us, -SpinLim, SpinLim);
      ul = clamp_to(ux + us, -WheelLim, WheelLim);
      ur = clamp_to(ux - us, -WheelLim, WheelLim);
    end
    res.left  = TorqueW'(ul);
    res.right = TorqueW'(ur);
    return res;
  endfunction

  // keeps counting past the print cap so a broken run stays readable
  task automatic report_mismatch(string what, longint got, longint exp_val);
    if (mismatch_cnt_o < PrintCap) begin
      $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, exp_val);
    end
    mismatch_cnt_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_pos          = 0;
      k_vel          = 0;
      k_spin         = 0;
      k_spin_rate    = 0;
      lim_lo         = 0;
      lim_hi         = longint'(UpperLimitRst);
      ctrl_en        = 1'b0;
      drive_en       = 1'b0;
      ref_fwd        = 0;
      ref_fwd_rate   = 0;
      ref_spin       = 0;
      ref_spin_rate  = 0;
      heading_up     = 1'b1;
      ref_held       = 1'b0;
      mismatch_cnt_o = 0;
      torque_q.delete();
      pending_cnt_o <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[AddrW-1:2]))
          REG_GAIN_POS:       k_pos       = longint'($signed(pwdata[GainW-1:0]));
          REG_GAIN_VEL:       k_vel       = longint'($signed(pwdata[GainW-1:0]));
          REG_GAIN_SPIN:      k_spin      = longint'($signed(pwdata[GainW-1:0]));
          REG_GAIN_SPIN_RATE: k_spin_rate = longint'($signed(pwdata[GainW-1:0]));
          REG_LOWER_LIMIT:    lim_lo      = longint'($signed(pwdata[ValW-1:0]));
          REG_UPPER_LIMIT:    lim_hi      = longint'($signed(pwdata[ValW-1:0]));
          REG_CONTROL_ENABLE: ctrl_en     = pwdata[0];
          REG_DRIVE_ENABLE:   drive_en    = pwdata[0];
          default: ;
        endcase
      end

      if (s_axis_tvalid_i && s_axis_tready_i) begin
        torque_q.push_back(predict_torques(s_axis_tdata_i, s_axis_tuser_i));
      end

      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got_left  = m_axis_tdata_i[0 +: TorqueW];
        got_right = m_axis_tdata_i[TorqueW +: TorqueW];
        if (torque_q.size() == 0) begin
          report_mismatch("unexpected transaction, left_torque", got_left, 0);
        end else begin
          want = torque_q.pop_front();
          if (got_left !== want.left) begin
            report_mismatch("left_torque", got_left, want.left);
          end
          if (got_right !== want.right) begin
            report_mismatch("right_torque", got_right, want.right);
          end
        end
      end

      pending_cnt_o <= torque_q.size();
    end
  end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import ddsf_pkg::*;

  localparam int unsigned CycleLimit = 300000;
  localparam logic [31:0] QMax       = 32'h7FFF_FFFF;
  localparam logic [31:0] QMin       = 32'h8000_0000;

  logic                clk_i;
  logic                rst_ni   = 1'b0;
  logic                psel     = 1'b0;
  logic                penable  = 1'b0;
  logic                pwrite   = 1'b0;
  logic [AddrW-1:0]    paddr    = '0;
  logic [DataW-1:0]    pwdata   = '0;
  logic [DataW-1:0]    prdata;
  logic                pready;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata  = '0;
  logic                s_tuser  = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;

  int unsigned mismatch_cnt, pending_cnt, cycle_cnt;
  bit          stall_on = 1'b1;

  // synthetic plant that sweeps forward position between the limits
  int plant_fwd, plant_spin, lim_lo, lim_hi;
  bit plant_up;

  diff_drive_state_feedback_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  torque_checker u_torque_chk (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .pready          (pready),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_tdata),
    .mismatch_cnt_o  (mismatch_cnt),
    .pending_cnt_o   (pending_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    m_tready <= !(stall_on && $urandom_range(0, 99) < 16);
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("simulation failed");
    $finish;
  end

  function automatic int small_rand(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic logic [31:0] corner_val();
    case ($urandom_range(0, 4))
      0:       return QMax;
      1:       return QMin;
      2:       return 32'd0;
      3:       return 32'hFFFF_FFFF;
      default: return 32'd1;
    endcase
  endfunction

  function automatic logic signed [15:0] rand_gain();
    if ($urandom_range(0, 99) < 80) return 16'(small_rand(1024));
    return 16'($urandom_range(0, 65535));
  endfunction

  task automatic send_sample(input logic [31:0] lp, input logic [31:0] rp,
                             input logic [31:0] lv, input logic [31:0] rv,
                             input logic [31:0] ti, input logic [31:0] tr,
                             input logic cap);
    while (stall_on && $urandom_range(0, 99) < 16) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {tr, ti, rv, lv, rp, lp};
    s_tuser  <= cap;
    do @(posedge clk_i); while (!s_tready);
  endtask

  // hold the sender until every torque transaction is back, then let the pipe settle
  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_cnt != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic apb_write(input reg_idx_e idx, input logic [31:0] val);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= AddrW'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic setup(input logic signed [15:0] gp, input logic signed [15:0] gv,
                       input logic signed [15:0] gs, input logic signed [15:0] gsr,
                       input logic signed [31:0] lo, input logic signed [31:0] hi,
                       input bit ce, input bit de);
    drain_results();
    apb_write(REG_GAIN_POS,       {{16{gp[15]}}, gp});
    apb_write(REG_GAIN_VEL,       {{16{gv[15]}}, gv});
    apb_write(REG_GAIN_SPIN,      {{16{gs[15]}}, gs});
    apb_write(REG_GAIN_SPIN_RATE, {{16{gsr[15]}}, gsr});
    apb_write(REG_LOWER_LIMIT,    lo);
    apb_write(REG_UPPER_LIMIT,    hi);
    apb_write(REG_CONTROL_ENABLE, {31'd0, ce});
    apb_write(REG_DRIVE_ENABLE,   {31'd0, de});
    lim_lo     = lo;
    lim_hi     = hi;
    plant_fwd  = int'((longint'(lo) + longint'(hi)) / 2);
    plant_spin = 0;
    plant_up   = 1'b1;
  endtask

  task automatic rand_setup(input bit ce, input bit de);
    int lo, hi, tmp;
    lo = -int'($urandom_range(0, 300000));
    hi = int'($urandom_range(0, 300000));
    if ($urandom_range(0, 9) == 0) begin
      tmp = lo;
      lo  = hi;
      hi  = tmp;
    end
    setup(rand_gain(), rand_gain(), rand_gain(), rand_gain(), lo, hi, ce, de);
  endtask

  task automatic send_random_sample();
    int mode, tilt;
    mode = $urandom_range(0, 99);
    if (mode < 65) begin
      // well-formed tick: forward follows a triangle sweep so the reference keeps stepping
      if (plant_fwd > lim_hi) plant_up = 1'b0;
      if (plant_fwd < lim_lo) plant_up = 1'b1;
      plant_fwd  += (plant_up ? FwdStep : -FwdStep) + small_rand(600);
      plant_spin += small_rand(800);
      tilt = small_rand(1500);
      send_sample(plant_fwd - tilt - plant_spin, plant_fwd - tilt + plant_spin,
                  small_rand(20000), small_rand(20000), tilt, small_rand(5000),
                  $urandom_range(0, 99) < 4);
    end else if (mode < 80) begin
      send_sample(small_rand(1 << 20), small_rand(1 << 20), small_rand(1 << 20),
                  small_rand(1 << 20), small_rand(1 << 20), small_rand(1 << 20),
                  $urandom_range(0, 99) < 20);
    end else if (mode < 92) begin
      send_sample($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom_range(0, 1));
    end else begin
      send_sample(corner_val(), corner_val(), corner_val(), corner_val(),
                  corner_val(), corner_val(), $urandom_range(0, 1));
    end
  endtask

  task automatic run_random(input int n);
    repeat (n) send_random_sample();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: torques forced to zero while the reference still tracks
    send_sample(0, 0, 0, 0, 0, 0, 1'b0);
    send_sample(QMax, QMax, QMax, QMax, QMax, QMax, 1'b0);
    send_sample(QMin, QMin, QMin, QMin, QMin, QMin, 1'b1);

    setup(16'sd256, 16'sd64, 16'sd128, 16'sd32, -32'sd65536, 32'sd65536, 1'b1, 1'b1);
    send_sample(0, 0, 0, 0, 0, 0, 1'b1);
    send_sample(1000, 1000, 0, 0, 0, 0, 1'b0);
    send_sample(200000, 200000, 0, 0, 0, 0, 1'b0);
    send_sample(100000, 100000, 500, -500, 0, 0, 1'b1);
    // measured values beyond 32 bits saturate on capture
    send_sample(QMax, QMax, QMax, QMax, QMax, QMax, 1'b1);
    send_sample(QMin, QMin, QMin, QMin, QMin, QMin, 1'b1);
    send_sample(QMin, QMax, 0, 0, 0, 0, 1'b0);
    send_sample(QMax, QMin, QMax, QMin, 0, 0, 1'b0);
    send_sample(-70000, -70000, 0, 0, 0, 0, 1'b1);

    // reference step saturates at the top of the range
    setup(16'sh7FFF, -16'sh8000, -16'sh8000, 16'sh7FFF, QMin, QMax, 1'b1, 1'b1);
    send_sample(QMax, QMax, 0, 0, 0, 0, 1'b1);
    send_sample(QMax, QMax, 0, 0, 0, 0, 1'b0);
    send_sample(1, -1, -1, 1, 1, -1, 1'b1);
    send_sample(-3, 0, 0, -3, 0, 0, 1'b0);

    // and at the bottom, once the direction has turned down
    setup(-16'sh8000, 16'sh7FFF, 16'sh7FFF, -16'sh8000, QMin, QMin, 1'b1, 1'b1);
    send_sample(QMax, QMax, 0, 0, 0, 0, 1'b1);
    send_sample(QMin, QMin, 0, 0, 0, 0, 1'b1);
    send_sample(QMin, QMin, 0, 0, 0, 0, 1'b0);

    // lower limit above upper limit: both tests pass and heading ends up forward
    setup(16'sd256, 16'sd64, 16'sd128, 16'sd32, 32'sd65536, -32'sd65536, 1'b1, 1'b1);
    send_sample(100000, 100000, 0, 0, 0, 0, 1'b1);
    send_sample(0, 0, 0, 0, 0, 0, 1'b1);
    send_sample(-100000, -100000, 0, 0, 0, 0, 1'b1);
    run_random(40);

    rand_setup(1'b1, 1'b0);
    run_random(150);
    rand_setup(1'b0, 1'b1);
    run_random(150);

    rand_setup(1'b1, 1'b1);
    stall_on = 1'b0;
    run_random(300);
    stall_on = 1'b1;

    rand_setup(1'b1, 1'b1);
    run_random(100);
    drain_results();
    run_random(100);

    repeat (3) begin
      rand_setup(1'b1, 1'b1);
      run_random(200);
    end

    drain_results();
    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/ddsf_pkg.sv
hdl/diff_drive_state_feedback_unit.sv
hdl/ddsf_checker.sv
bench/torque_checker.sv
bench/testbench.sv
